FILE: src/dsf_pkg.sv
package dsf_pkg;

    localparam int MAX_SPS    = 64;
    localparam int POS_W      = $clog2(MAX_SPS);
    localparam int SAMPLE_W   = 16;
    localparam int NUM_ROWS   = 16;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int GROUPS     = 4;
    localparam int PER_GROUP  = NUM_ROWS / GROUPS;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = 38;
    localparam int LEN_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEN_W-1:0] MAX_FRAME = 7'd127;

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_LENGTH,
        MODE_PAYLOAD
    } mode_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TABLE  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sync;
        logic [ROW_W-1:0]           row;
        logic [POS_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

FILE: src/dsf_ram.sv
module dsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dsf_front.sv
module dsf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsf_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [dsf_pkg::IN_USER_W-1:0]       s_tuser,
    output dsf_pkg::queue_head_t                head,
    input  logic                                pop
);
    import dsf_pkg::*;

    item_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    item_t               in_item;
    logic                push;
    logic                take;

    // classify the beat into a queue entry
    always_comb
    begin
        in_item.op     = op_t'(s_tuser[0]);
        in_item.sync   = s_tuser[1];
        in_item.sample = s_tdata[15:0];
        in_item.addr   = s_tdata[16 +: POS_W];
        in_item.row    = s_tdata[16 + POS_W +: ROW_W];
        in_item.value  = s_tdata[41:26];
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign head     = '{valid: (count_reg != '0), item: mem_reg[rd_ptr_reg]};
    assign take     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: src/dsf_back.sv
module dsf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dsf_pkg::queue_head_t               head,
    output logic                               pop,
    input  logic [dsf_pkg::LEN_W-1:0]          symbol_len,
    input  logic [dsf_pkg::BYTE_W-1:0]         preset_length,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dsf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);
    import dsf_pkg::*;

    mode_t                      mode_reg, mode_next;
    logic [POS_W-1:0]           count_reg, count_next;
    logic                       busy_reg, busy_next;
    logic                       nib_reg, nib_next;
    logic [3:0]                 low_reg, low_next;
    logic [LEN_W-1:0]           cur_reg, cur_next;
    logic [LEN_W-1:0]           left_reg, left_next;

    logic                       v1_reg, end1_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic                       v2_reg, end2_reg;
    logic                       end3_reg;
    logic                       v4_reg;
    logic signed [PROD_W-1:0]   prod_reg [NUM_ROWS];
    logic signed [ACC_W-1:0]    acc_reg  [NUM_ROWS];
    logic signed [ACC_W-1:0]    gval_reg [GROUPS];
    logic [ROW_W-1:0]           gidx_reg [GROUPS];
    logic signed [ACC_W-1:0]    gval_c   [GROUPS];
    logic [ROW_W-1:0]           gidx_c   [GROUPS];
    logic [SAMPLE_W-1:0]        rdata    [NUM_ROWS];

    logic                       out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]          out_byte_reg;
    logic [LEN_W-1:0]           out_len_reg;
    logic                       out_last_reg, out_empty_reg;

    logic [LEN_W-1:0]           eff_len;
    logic                       is_end;
    logic                       is_sample, acc_issue;
    logic [ROW_W-1:0]           sym;
    logic signed [ACC_W-1:0]    best_v;
    logic [BYTE_W-1:0]          byte_val, n_val;
    logic [LEN_W-1:0]           left_dec;
    logic                       emit;
    logic [BYTE_W-1:0]          e_byte;
    logic [LEN_W-1:0]           e_len;
    logic                       e_last, e_empty;

    // symbol length as applied: zero acts as one, clamp to the table depth
    always_comb
    begin
        priority if (symbol_len == '0)
            eff_len = LEN_W'(1);
        else if (symbol_len > LEN_W'(MAX_SPS))
            eff_len = LEN_W'(MAX_SPS);
        else
            eff_len = symbol_len;
    end

    assign is_end    = ({1'b0, count_reg} + LEN_W'(1)) >= eff_len;
    assign is_sample = (head.item.op == OP_SAMPLE);

    // a symbol-ending sample needs a free output slot and holds the back end
    assign pop = head.valid && !busy_reg &&
                 !(is_sample && mode_reg != MODE_SEARCH && is_end && out_valid_reg);
    assign acc_issue = pop && is_sample && (mode_reg != MODE_SEARCH);

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        dsf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SPS)) u_ram (
            .clk   (clk),
            .we    (pop && !is_sample && head.item.row == ROW_W'(r)),
            .waddr (head.item.addr),
            .wdata (head.item.value),
            .raddr (count_reg),
            .rdata (rdata[r])
        );

        always_ff @(posedge clk)
        begin
            if (v1_reg)
            begin
                prod_reg[r] <= x1_reg * $signed(rdata[r]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[r] <= '0;
            end
            else if (end3_reg)
            begin
                acc_reg[r] <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg[r] <= acc_reg[r] + ACC_W'(prod_reg[r]);
            end
        end
    end

    // first level of the argmax: lowest row wins a tie
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            gval_c[g] = acc_reg[g*PER_GROUP];
            gidx_c[g] = ROW_W'(g*PER_GROUP);
            for (int k = 1; k < PER_GROUP; k++)
            begin
                if (acc_reg[g*PER_GROUP+k] > gval_c[g])
                begin
                    gval_c[g] = acc_reg[g*PER_GROUP+k];
                    gidx_c[g] = ROW_W'(g*PER_GROUP+k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end3_reg)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                gval_reg[g] <= gval_c[g];
                gidx_reg[g] <= gidx_c[g];
            end
        end
        if (acc_issue)
        begin
            x1_reg <= head.item.sample;
        end
    end

    // second level of the argmax
    always_comb
    begin
        best_v = gval_reg[0];
        sym    = gidx_reg[0];
        for (int g = 1; g < GROUPS; g++)
        begin
            if (gval_reg[g] > best_v)
            begin
                best_v = gval_reg[g];
                sym    = gidx_reg[g];
            end
        end
    end

    assign byte_val = {sym, low_reg};
    assign n_val    = (preset_length != '0) ? preset_length : byte_val;
    assign left_dec = (left_reg != '0) ? left_reg - LEN_W'(1) : left_reg;

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        nib_next   = nib_reg;
        low_next   = low_reg;
        cur_next   = cur_reg;
        left_next  = left_reg;
        if (pop && is_sample && mode_reg == MODE_SEARCH && head.item.sync)
        begin
            mode_next  = MODE_LENGTH;
            count_next = '0;
            nib_next   = 1'b0;
            low_next   = '0;
        end
        if (acc_issue)
        begin
            count_next = is_end ? '0 : count_reg + POS_W'(1);
            busy_next  = is_end;
        end
        if (v4_reg)
        begin
            busy_next = 1'b0;
            if (!nib_reg)
            begin
                low_next = sym;
                nib_next = 1'b1;
            end
            else
            begin
                nib_next = 1'b0;
                unique case (mode_reg)
                    MODE_LENGTH:
                    begin
                        if (n_val > BYTE_W'(MAX_FRAME))
                        begin
                            mode_next = MODE_SEARCH;
                        end
                        else
                        begin
                            cur_next  = n_val[LEN_W-1:0];
                            left_next = n_val[LEN_W-1:0];
                            mode_next = (n_val == '0) ? MODE_SEARCH : MODE_PAYLOAD;
                        end
                    end
                    MODE_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            mode_next = MODE_SEARCH;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    // result outputs
    always_comb
    begin
        emit    = 1'b0;
        e_byte  = '0;
        e_len   = '0;
        e_last  = 1'b0;
        e_empty = 1'b0;
        if (v4_reg && nib_reg)
        begin
            unique case (mode_reg)
                MODE_LENGTH:
                begin
                    if (n_val == '0)
                    begin
                        emit    = 1'b1;
                        e_last  = 1'b1;
                        e_empty = 1'b1;
                    end
                end
                MODE_PAYLOAD:
                begin
                    emit   = 1'b1;
                    e_byte = byte_val;
                    e_len  = cur_reg;
                    e_last = (left_dec == '0);
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SEARCH;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            nib_reg       <= 1'b0;
            low_reg       <= '0;
            cur_reg       <= '0;
            left_reg      <= '0;
            v1_reg        <= 1'b0;
            end1_reg      <= 1'b0;
            v2_reg        <= 1'b0;
            end2_reg      <= 1'b0;
            end3_reg      <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            nib_reg       <= nib_next;
            low_reg       <= low_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            v1_reg        <= acc_issue;
            end1_reg      <= acc_issue && is_end;
            v2_reg        <= v1_reg;
            end2_reg      <= end1_reg;
            end3_reg      <= v2_reg && end2_reg;
            v4_reg        <= end3_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= e_byte;
            out_len_reg   <= e_len;
            out_last_reg  <= e_last;
            out_empty_reg <= e_empty;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {1'b0, out_len_reg, out_byte_reg};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_empty_reg;

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !pop) else $error("back end popped while a symbol resolves");
    a_decide_busy: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> busy_reg) else $error("symbol decision without hold");
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg) else $error("result overwrote a pending beat");
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PAYLOAD) |-> (left_reg != '0)) else $error("payload with no bytes left");

endmodule

FILE: src/dsss_symbol_frame_demodulator.sv
// Channel  | Dir | Signals                        | Contents (lowest bit up)
// s_       | in  | s_tvalid s_tready s_tdata s_tuser | tdata: sample[15:0], table_index[25:16],
//          |     |                                | table_value[41:26], zero pad; tuser: op, sync_flag
// m_       | out | m_tvalid m_tready m_tdata m_tuser m_tlast | tdata: payload_byte[7:0],
//          |     |                                | frame_bytes[14:8], zero pad; tuser: empty_frame
// cfg_     | in  | cfg_we cfg_index cfg_data      | 0 symbol_len, 1 preset_length
//
// Samples and table writes go one per cycle unless the back end is held; a symbol-ending
// sample holds it for RAM read, sixteen multiplies, accumulate, two-level argmax, framing.
// A 4-beat queue parts the input from the back end; one output register holds a result beat,
// and a symbol-ending sample waits while that register is still full.
// rst_n is asynchronous: it returns to search mode and empties the queue; the reference
// table holds no reset value and must be written before use.
module dsss_symbol_frame_demodulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsf_pkg::IN_DATA_W-1:0]       s_tdata,   // sample, table_index, table_value
    input  logic [dsf_pkg::IN_USER_W-1:0]       s_tuser,   // op, sync_flag
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dsf_pkg::OUT_DATA_W-1:0]      m_tdata,   // payload_byte, frame_bytes
    output logic [0:0]                          m_tuser,   // empty_frame
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [dsf_pkg::BYTE_W-1:0]          cfg_data
);
    import dsf_pkg::*;

    localparam logic CFG_SYMBOL_LEN    = 1'b0;
    localparam logic CFG_PRESET_LENGTH = 1'b1;

    logic [LEN_W-1:0]  symbol_len_reg;
    logic [BYTE_W-1:0] preset_length_reg;
    queue_head_t       head;
    logic              pop;

    // configuration registers: the user must write them only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_len_reg    <= LEN_W'(32);
            preset_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYMBOL_LEN:    symbol_len_reg    <= cfg_data[LEN_W-1:0];
                CFG_PRESET_LENGTH: preset_length_reg <= cfg_data;
                default:           symbol_len_reg    <= symbol_len_reg;
            endcase
        end
    end

    // front: classify beats and queue them
    dsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    // back: table RAMs, correlators, argmax, framing
    dsf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .symbol_len    (symbol_len_reg),
        .preset_length (preset_length_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule
